// File: hw/rtl/qbg_pkg.sv
// Package for the quantized bias-add GELU block: shared widths, the record types
// that travel down the pipeline, fixed-point constants and the erf coefficient table.
// No dependencies.
`default_nettype none

package qbg_pkg;

    // Datapath widths
    localparam int X_W   = 36;  // signed dequantized sum, Q16
    localparam int A_W   = 35;  // magnitude of the sum
    localparam int AS_W  = 19;  // magnitude when it lies below six
    localparam int Z_W   = 31;  // |x|/sqrt2 in Q28
    localparam int P_W   = 32;  // polynomial and divisor values, Q28
    localparam int R_W   = 29;  // reciprocal and its powers, Q28
    localparam int C_W   = 30;  // one plus or minus erf, Q28
    localparam int ADDR_W = 5;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_SIGNED_MODE = 3'd0;
    localparam logic [2:0] REG_ACT_SCALE   = 3'd1;
    localparam logic [2:0] REG_ACT_ZP      = 3'd2;
    localparam logic [2:0] REG_COL_SCALE   = 3'd3;
    localparam logic [2:0] REG_COL_ZP      = 3'd4;

    localparam logic [P_W-1:0] Q28_ONE   = 32'h1000_0000;
    localparam logic [27:0]    INV_SQRT2 = 28'd189812531;
    localparam logic [A_W-1:0] SIX_Q16   = 35'd393216;

    typedef struct packed {
        logic        signed_mode;
        logic [23:0] act_scale;
        logic [7:0]  act_zp;
        logic [23:0] col_scale;
        logic [7:0]  col_zp;
    } cfg_t;

    // Per-item record carried alongside the erf datapath.
    typedef struct packed {
        logic           last;
        logic           neg;
        logic           big;
        logic [A_W-1:0] mag;
    } side_t;

    function automatic logic [P_W-1:0] erf_coef(input int idx);
        logic [P_W-1:0] v;
        begin
            case (idx)
                0:       v = 32'd18930895;
                1:       v = 32'd11349991;
                2:       v = 32'd2488538;
                3:       v = 32'd40806;
                4:       v = 32'd74240;
                5:       v = 32'd11560;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Byte read as int8 or uint8, widened to ten signed bits.
    function automatic logic [9:0] byte_value(input logic smode, input logic [7:0] b);
        begin
            return {{2{smode & b[7]}}, b};
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qbg_front.sv
// Front end: dequantizes both codes, forms the sum, its magnitude and |x|/sqrt2.
// Depends on qbg_pkg.
`default_nettype none

module qbg_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire logic [7:0]                input_code,
    input  wire logic [7:0]                bias_code,
    input  wire logic                      row_last,
    input  wire qbg_pkg::cfg_t             cfg,
    output logic                           out_valid,
    output logic [qbg_pkg::Z_W-1:0]        z,
    output qbg_pkg::side_t                 side
);

    localparam int XW = qbg_pkg::X_W;

    logic [9:0]           di;
    logic [9:0]           db;
    logic signed [XW-1:0] di_x;
    logic signed [XW-1:0] db_x;
    logic signed [XW-1:0] is_x;
    logic signed [XW-1:0] bs_x;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] x_reg;
    logic                 last1_reg;
    logic                 v1_reg;
    logic                 v2_reg;

    logic                           neg;
    logic [qbg_pkg::A_W-1:0]        mag;
    logic [46:0]                    zprod;
    logic [qbg_pkg::Z_W-1:0]        z_reg;
    qbg_pkg::side_t                 side_next;
    qbg_pkg::side_t                 side_reg;

    assign di = qbg_pkg::byte_value(cfg.signed_mode, input_code)
              - qbg_pkg::byte_value(cfg.signed_mode, cfg.act_zp);
    assign db = qbg_pkg::byte_value(cfg.signed_mode, bias_code)
              - qbg_pkg::byte_value(cfg.signed_mode, cfg.col_zp);

    assign di_x = $signed({{(XW-10){di[9]}}, di});
    assign db_x = $signed({{(XW-10){db[9]}}, db});
    assign is_x = $signed({{(XW-24){1'b0}}, cfg.act_scale});
    assign bs_x = $signed({{(XW-24){1'b0}}, cfg.col_scale});
    assign x_next = di_x * is_x + db_x * bs_x;

    // The sum stays below 2^33 in magnitude, so its negation fits the magnitude field.
    assign neg   = x_reg[XW-1];
    assign mag   = neg ? qbg_pkg::A_W'(-x_reg) : qbg_pkg::A_W'(x_reg);
    assign zprod = 47'(mag[qbg_pkg::AS_W-1:0]) * 47'(qbg_pkg::INV_SQRT2);

    always_comb
    begin
        side_next.last = last1_reg;
        side_next.neg  = neg;
        side_next.big  = (mag >= qbg_pkg::SIX_Q16);
        side_next.mag  = mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg     <= x_next;
            last1_reg <= row_last;
            z_reg     <= zprod[46:16];
            side_reg  <= side_next;
        end
    end

    assign out_valid = v2_reg;
    assign z         = z_reg;
    assign side      = side_reg;

endmodule

`default_nettype wire

// File: hw/rtl/qbg_poly.sv
// Horner evaluation of the erf denominator polynomial, one multiply per stage.
// Depends on qbg_pkg.
`default_nettype none

module qbg_poly (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire logic [qbg_pkg::Z_W-1:0]   z,
    input  wire qbg_pkg::side_t            side_in,
    output logic                           out_valid,
    output logic [qbg_pkg::P_W-1:0]        d,
    output qbg_pkg::side_t                 side_out
);

    localparam int STEPS = 6;

    logic [STEPS-1:0]          v_reg;
    logic [qbg_pkg::P_W-1:0]   p_reg    [STEPS];
    logic [qbg_pkg::Z_W-1:0]   z_reg    [STEPS];
    qbg_pkg::side_t            side_reg [STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[STEPS-2:0], in_valid};
        end
    end

    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        logic [qbg_pkg::P_W-1:0] p_src;
        logic [qbg_pkg::Z_W-1:0] z_src;
        qbg_pkg::side_t          s_src;
        logic [62:0]             prod;
        logic [qbg_pkg::P_W-1:0] addend;

        if (j == 0)
        begin : g_first
            assign p_src = qbg_pkg::erf_coef(5);
            assign z_src = z;
            assign s_src = side_in;
        end
        else
        begin : g_next
            assign p_src = p_reg[j-1];
            assign z_src = z_reg[j-1];
            assign s_src = side_reg[j-1];
        end

        // The last step adds one to form the divisor of the reciprocal.
        if (j == STEPS - 1)
        begin : g_one
            assign addend = qbg_pkg::Q28_ONE;
        end
        else
        begin : g_coef
            assign addend = qbg_pkg::erf_coef(STEPS - 2 - j);
        end

        assign prod = 63'(p_src) * 63'(z_src);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p_reg[j]    <= prod[59:28] + addend;
                z_reg[j]    <= z_src;
                side_reg[j] <= s_src;
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign d         = p_reg[STEPS-1];
    assign side_out  = side_reg[STEPS-1];

endmodule

`default_nettype wire

// File: hw/rtl/qbg_div.sv
// Pipelined restoring divider forming 2^56 / d, one quotient bit per stage.
// Depends on qbg_pkg.
`default_nettype none

module qbg_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire logic [qbg_pkg::P_W-1:0]   d,
    input  wire qbg_pkg::side_t            side_in,
    output logic                           out_valid,
    output logic [qbg_pkg::R_W-1:0]        r,
    output qbg_pkg::side_t                 side_out
);

    localparam int STEPS = qbg_pkg::R_W;

    logic [STEPS-1:0]          v_reg;
    logic [qbg_pkg::P_W-1:0]   rem_reg  [STEPS];
    logic [qbg_pkg::P_W-1:0]   d_reg    [STEPS];
    logic [qbg_pkg::R_W-1:0]   q_reg    [STEPS];
    qbg_pkg::side_t            side_reg [STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[STEPS-2:0], in_valid};
        end
    end

    for (genvar s = 0; s < STEPS; s++)
    begin : g_bit
        logic [qbg_pkg::P_W-1:0] rem_src;
        logic [qbg_pkg::P_W-1:0] d_src;
        logic [qbg_pkg::R_W-1:0] q_src;
        qbg_pkg::side_t          s_src;
        logic                    ge;
        logic [qbg_pkg::P_W-1:0] rem_sub;

        if (s == 0)
        begin : g_first
            // The dividend 2^56 shows up as 2^28 against the top quotient bit.
            assign rem_src = qbg_pkg::Q28_ONE;
            assign d_src   = d;
            assign q_src   = '0;
            assign s_src   = side_in;
        end
        else
        begin : g_next
            assign rem_src = rem_reg[s-1];
            assign d_src   = d_reg[s-1];
            assign q_src   = q_reg[s-1];
            assign s_src   = side_reg[s-1];
        end

        assign ge      = (rem_src >= d_src);
        assign rem_sub = ge ? (rem_src - d_src) : rem_src;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s]  <= {rem_sub[qbg_pkg::P_W-2:0], 1'b0};
                d_reg[s]    <= d_src;
                q_reg[s]    <= {q_src[qbg_pkg::R_W-2:0], ge};
                side_reg[s] <= s_src;
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign r         = q_reg[STEPS-1];
    assign side_out  = side_reg[STEPS-1];

endmodule

`default_nettype wire

// File: hw/rtl/qbg_back.sv
// Back end: raises the reciprocal to the sixteenth power, forms erf and the GELU
// product, then scales and saturates into the output register. Depends on qbg_pkg.
`default_nettype none

module qbg_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire logic [qbg_pkg::R_W-1:0]   r,
    input  wire qbg_pkg::side_t            side_in,
    output logic                           out_valid,
    output logic [31:0]                    gelu_value,
    output logic                           row_last_out
);

    localparam int SQ     = 4;
    localparam int PROD_W = qbg_pkg::AS_W + qbg_pkg::C_W;
    localparam int SHR_S  = 45 - FRAC_BITS;
    localparam int SHL_B  = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
    localparam int SHR_B  = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;

    logic [SQ+1:0]             v_reg;
    logic [qbg_pkg::R_W-1:0]   r_reg    [SQ];
    qbg_pkg::side_t            side_reg [SQ];

    logic [qbg_pkg::R_W-1:0]   e;
    logic [qbg_pkg::C_W-1:0]   c;
    logic [PROD_W-1:0]         prod_reg;
    qbg_pkg::side_t            sidep_reg;

    logic [PROD_W-1:0]         small_mag;
    logic [PROD_W-1:0]         big_mag;
    logic [PROD_W-1:0]         mag;
    logic [31:0]               res_next;
    logic [31:0]               res_reg;
    logic                      last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[SQ:0], in_valid};
        end
    end

    for (genvar k = 0; k < SQ; k++)
    begin : g_sq
        logic [qbg_pkg::R_W-1:0] r_src;
        qbg_pkg::side_t          s_src;
        logic [57:0]             sq;

        if (k == 0)
        begin : g_first
            assign r_src = r;
            assign s_src = side_in;
        end
        else
        begin : g_next
            assign r_src = r_reg[k-1];
            assign s_src = side_reg[k-1];
        end

        assign sq = 58'(r_src) * 58'(r_src);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_reg[k]    <= sq[56:28];
                side_reg[k] <= s_src;
            end
        end
    end

    assign e = qbg_pkg::R_W'(qbg_pkg::Q28_ONE) - r_reg[SQ-1];
    assign c = side_reg[SQ-1].neg
             ? (qbg_pkg::C_W'(qbg_pkg::Q28_ONE) - qbg_pkg::C_W'(e))
             : (qbg_pkg::C_W'(qbg_pkg::Q28_ONE) + qbg_pkg::C_W'(e));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= PROD_W'(side_reg[SQ-1].mag[qbg_pkg::AS_W-1:0]) * PROD_W'(c);
            sidep_reg <= side_reg[SQ-1];
        end
    end

    // Beyond six the erf term is exactly one: the result is x itself or zero.
    assign small_mag = prod_reg >> SHR_S;
    assign big_mag   = (PROD_W'(sidep_reg.mag) << SHL_B) >> SHR_B;
    assign mag       = sidep_reg.big ? (sidep_reg.neg ? '0 : big_mag) : small_mag;

    always_comb
    begin
        if (sidep_reg.neg)
        begin
            if (mag > PROD_W'(33'h1_0000_0000 >> 1))
            begin
                res_next = 32'h8000_0000;
            end
            else
            begin
                res_next = ~mag[31:0] + 32'd1;
            end
        end
        else
        begin
            if (mag > PROD_W'(32'h7FFF_FFFF))
            begin
                res_next = 32'h7FFF_FFFF;
            end
            else
            begin
                res_next = mag[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg  <= res_next;
            last_reg <= sidep_reg.last;
        end
    end

    assign out_valid    = v_reg[SQ+1];
    assign gelu_value   = res_reg;
    assign row_last_out = last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/quantized_bias_add_gelu.sv
// Top level of the quantized bias-add GELU block: configuration registers, the
// pipeline control and the four datapath sections. Depends on qbg_pkg and qbg_*.
//
// Usage. Each transfer on the act channel (act_valid/act_ready) carries one
// activation code, the bias code for its column and a row-end flag. Both codes
// are dequantized with their zero point and scale, added, and GELU with
// an erf approximation is applied. Each transfer on the res channel
// (res_valid/res_ready) returns the signed fixed-point result with FRAC_BITS
// fraction bits, saturated to 32 bits, and the row-end flag. Results leave in
// the order that items arrived. Throughput is one item per cycle unless the
// receiver stalls. The pipeline has two front stages, six Horner
// stages, 29 divider stages (one quotient bit each, which sets most of the
// depth), four squaring stages, one product stage and the output register.
// The whole pipeline advances together whenever the output register is empty or
// its result is being taken; while the receiver stalls, act_ready is low and
// every stage holds its contents, so nothing is lost or repeated. Reset clears
// every valid bit and returns the registers to unsigned mode, scales of one and
// zero points of zero. The user writes the APB port only when idle; unenforced.
`default_nettype none

module quantized_bias_add_gelu #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [qbg_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        act_valid,
    output logic                             act_ready,
    input  wire logic [7:0]                  input_code,
    input  wire logic [7:0]                  bias_code,
    input  wire logic                        row_last,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output logic signed [31:0]               gelu_value,
    output logic                             row_last_out
);

    logic            signed_mode_reg;
    logic [23:0]     act_scale_reg;
    logic [7:0]      act_zp_reg;
    logic [23:0]     col_scale_reg;
    logic [7:0]      col_zp_reg;
    logic            wr_en;
    logic [2:0]      reg_idx;
    qbg_pkg::cfg_t   cfg;

    logic                          adv;
    logic                          f_valid;
    logic [qbg_pkg::Z_W-1:0]       f_z;
    qbg_pkg::side_t                f_side;
    logic                          p_valid;
    logic [qbg_pkg::P_W-1:0]       p_d;
    qbg_pkg::side_t                p_side;
    logic                          d_valid;
    logic [qbg_pkg::R_W-1:0]       d_r;
    qbg_pkg::side_t                d_side;
    logic [31:0]                   b_value;

    // Register file. Writes complete in the access phase; pready stays high.
    assign pready  = 1'b1;
    assign reg_idx = paddr[qbg_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b0;
            act_scale_reg   <= 24'd65536;
            act_zp_reg      <= 8'd0;
            col_scale_reg   <= 24'd65536;
            col_zp_reg      <= 8'd0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                qbg_pkg::REG_SIGNED_MODE: signed_mode_reg <= pwdata[0];
                qbg_pkg::REG_ACT_SCALE:   act_scale_reg   <= pwdata[23:0];
                qbg_pkg::REG_ACT_ZP:      act_zp_reg      <= pwdata[7:0];
                qbg_pkg::REG_COL_SCALE:   col_scale_reg   <= pwdata[23:0];
                qbg_pkg::REG_COL_ZP:      col_zp_reg      <= pwdata[7:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            qbg_pkg::REG_SIGNED_MODE: prdata = {31'd0, signed_mode_reg};
            qbg_pkg::REG_ACT_SCALE:   prdata = {8'd0, act_scale_reg};
            qbg_pkg::REG_ACT_ZP:      prdata = {24'd0, act_zp_reg};
            qbg_pkg::REG_COL_SCALE:   prdata = {8'd0, col_scale_reg};
            qbg_pkg::REG_COL_ZP:      prdata = {24'd0, col_zp_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        cfg.signed_mode = signed_mode_reg;
        cfg.act_scale   = act_scale_reg;
        cfg.act_zp      = act_zp_reg;
        cfg.col_scale   = col_scale_reg;
        cfg.col_zp      = col_zp_reg;
    end

    // Every stage moves on when the output register can take a new result.
    assign adv       = !res_valid || res_ready;
    assign act_ready = adv;

    qbg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (act_valid),
        .input_code (input_code),
        .bias_code  (bias_code),
        .row_last   (row_last),
        .cfg        (cfg),
        .out_valid  (f_valid),
        .z          (f_z),
        .side       (f_side)
    );

    qbg_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .z         (f_z),
        .side_in   (f_side),
        .out_valid (p_valid),
        .d         (p_d),
        .side_out  (p_side)
    );

    qbg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p_valid),
        .d         (p_d),
        .side_in   (p_side),
        .out_valid (d_valid),
        .r         (d_r),
        .side_out  (d_side)
    );

    qbg_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (d_valid),
        .r            (d_r),
        .side_in      (d_side),
        .out_valid    (res_valid),
        .gelu_value   (b_value),
        .row_last_out (row_last_out)
    );

    assign gelu_value = $signed(b_value);

endmodule

`default_nettype wire

// File: hw/rtl/qbg_checker.sv
// Port-level checker for the quantized bias-add GELU block, bound to its top level.
// Depends on the top level's ports only.
`default_nettype none

module qbg_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        act_ready,
    input  wire logic        res_valid,
    input  wire logic        res_ready,
    input  wire logic [31:0] gelu_value
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(gelu_value))
        else $error("stalled result changed");

    // With no result waiting the block always takes a new item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> act_ready)
        else $error("input refused while output empty");

    // A stalled output stops intake so that no item is dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !act_ready)
        else $error("input taken while output stalled");

    // GELU is never below about -0.17, so negative results stay small.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && gelu_value[31] |-> gelu_value[30:28] == 3'b111)
        else $error("negative result out of range");

endmodule

bind quantized_bias_add_gelu qbg_checker u_qbg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .act_ready  (act_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .gelu_value (gelu_value)
);

`default_nettype wire
